### design/assert_macros.svh
// Assertion macros shared by the tray margin selector RTL.
// Included by the modules that carry concurrent checks; needs clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check sampled on clk, masked while rst is high.
`define CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Check sampled on clk, live through reset as well.
`define CHK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

### design/tmbs_pkg.sv
// Types, constants and helpers for the tray margin best-box selector.
// No dependencies; used by every other file of the block.
`default_nettype none

package tmbs_pkg;

  localparam int CW         = 12;  // pixel coordinate width
  localparam int HT_W       = 16;  // height in mm
  localparam int CNT_W      = 8;   // box index width
  localparam int THR_W      = 26;  // signed width of scaled margin lines
  localparam int REG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ROI_WIDTH  = 3'd0,
    REG_ROI_HEIGHT = 3'd1,
    REG_TRAY_COUNT = 3'd2,
    REG_TRAY_WIDTH = 3'd3,
    REG_SIDE_RATIO = 3'd4,
    REG_EDGE_RATIO = 3'd5,
    REG_ROW_OFFSET = 3'd6
  } reg_idx_t;

  localparam logic [CW-1:0] RST_ROI_WIDTH  = 12'd640;
  localparam logic [CW-1:0] RST_ROI_HEIGHT = 12'd480;
  localparam logic [3:0]    RST_TRAY_COUNT = 4'd1;
  localparam logic [CW-1:0] RST_TRAY_WIDTH = 12'd640;
  localparam logic [7:0]    RST_SIDE_RATIO = 8'd26;
  localparam logic [7:0]    RST_EDGE_RATIO = 8'd26;
  localparam logic [CW-1:0] RST_ROW_OFFSET = 12'd0;

  typedef struct packed {
    logic [CW-1:0]          x_min;
    logic [CW-1:0]          x_max;
    logic [CW-1:0]          y_min;
    logic [CW-1:0]          y_max;
    logic signed [HT_W-1:0] height_mm;
    logic                   last_box;
  } box_t;

  typedef struct packed {
    logic             found;
    logic [CNT_W-1:0] best_index;
    logic [CW-1:0]    center_x;
    logic [CW-1:0]    center_y;
    logic [CW-1:0]    best_x_min;
    logic [CW-1:0]    best_y_min;
    logic [CW-1:0]    best_x_max;
    logic [CW-1:0]    best_y_max;
  } res_t;

  // Margin lines scaled by 256, compared against 256 * centre.
  typedef struct packed {
    logic signed [THR_W-1:0] left;
    logic signed [THR_W-1:0] right;
    logic signed [THR_W-1:0] top;
    logic signed [THR_W-1:0] bot;
  } thr_t;

  // Floor midpoint of two coordinates.
  function automatic logic [CW-1:0] mid(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CW:1];
  endfunction

endpackage

`default_nettype wire

### design/tmbs_if.sv
// Valid/ready channel interfaces for boxes in and results out.
// Depends on tmbs_pkg for the payload types.
`default_nettype none

interface tmbs_box_if;
  import tmbs_pkg::*;
  logic valid;
  logic ready;
  box_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tmbs_res_if;
  import tmbs_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### design/tmbs_cfg.sv
// Configuration registers and the registered margin lines derived from them.
// Depends on tmbs_pkg.
`default_nettype none

module tmbs_cfg #(
  parameter int MAX_TRAYS = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [tmbs_pkg::REG_IDX_W-1:0]    cfg_index,
  input  wire logic [tmbs_pkg::CFG_DATA_W-1:0]   cfg_data,
  output tmbs_pkg::thr_t                         thr,
  output logic signed [tmbs_pkg::THR_W-1:0]      div_lo [MAX_TRAYS],
  output logic signed [tmbs_pkg::THR_W-1:0]      div_hi [MAX_TRAYS],
  output logic [MAX_TRAYS-1:0]                   lane_en
);
  import tmbs_pkg::*;

  logic [CW-1:0]        roi_width;
  logic [CW-1:0]        roi_height;
  logic [3:0]           tray_count;
  logic [CW-1:0]        tray_width;
  logic [7:0]           side_ratio;
  logic [7:0]           edge_ratio;
  logic signed [CW-1:0] row_offset;

  logic signed [THR_W-1:0] tw_e, rs_e, re_e, h_e, w_e, off_s, side;
  thr_t thr_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      roi_width  <= RST_ROI_WIDTH;
      roi_height <= RST_ROI_HEIGHT;
      tray_count <= RST_TRAY_COUNT;
      tray_width <= RST_TRAY_WIDTH;
      side_ratio <= RST_SIDE_RATIO;
      edge_ratio <= RST_EDGE_RATIO;
      row_offset <= RST_ROW_OFFSET;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_ROI_WIDTH:  roi_width  <= cfg_data[CW-1:0];
        REG_ROI_HEIGHT: roi_height <= cfg_data[CW-1:0];
        REG_TRAY_COUNT: tray_count <= cfg_data[3:0];
        REG_TRAY_WIDTH: tray_width <= cfg_data[CW-1:0];
        REG_SIDE_RATIO: side_ratio <= cfg_data[7:0];
        REG_EDGE_RATIO: edge_ratio <= cfg_data[7:0];
        REG_ROW_OFFSET: row_offset <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  assign tw_e  = {{(THR_W-CW){1'b0}}, tray_width};
  assign w_e   = {{(THR_W-CW){1'b0}}, roi_width};
  assign h_e   = {{(THR_W-CW){1'b0}}, roi_height};
  assign rs_e  = {{(THR_W-8){1'b0}}, side_ratio};
  assign re_e  = {{(THR_W-8){1'b0}}, edge_ratio};
  assign off_s = THR_W'(row_offset) <<< 8;
  assign side  = rs_e * tw_e;

  always_comb begin
    thr_next.left  = side;
    thr_next.right = (w_e <<< 8) - side;
    thr_next.top   = re_e * h_e + off_s;
    thr_next.bot   = (THR_W'(256) - re_e) * h_e + off_s;
  end

  always_ff @(posedge clk) begin
    thr <= thr_next;
  end

  // One window per inner divider; lane 0 stays disabled.
  for (genvar k = 0; k < MAX_TRAYS; k++) begin : g_lane
    localparam logic signed [THR_W-1:0] BASE = THR_W'(k * 256);
    always_ff @(posedge clk) begin
      div_lo[k]  <= tw_e * (BASE - rs_e);
      div_hi[k]  <= tw_e * (BASE + rs_e);
      lane_en[k] <= (k != 0) && (4'(k) < tray_count);
    end
  end

endmodule

`default_nettype wire

### design/tmbs_near.sv
// Near-side test of a box centre against the edge and divider margin lines.
// Depends on tmbs_pkg.
`default_nettype none

module tmbs_near #(
  parameter int MAX_TRAYS = 8
) (
  input  wire logic [tmbs_pkg::CW-1:0]           cx,
  input  wire logic [tmbs_pkg::CW-1:0]           cy,
  input  wire tmbs_pkg::thr_t                    thr,
  input  wire logic signed [tmbs_pkg::THR_W-1:0] div_lo [MAX_TRAYS],
  input  wire logic signed [tmbs_pkg::THR_W-1:0] div_hi [MAX_TRAYS],
  input  wire logic [MAX_TRAYS-1:0]              lane_en,
  output logic                                   at_margin
);
  import tmbs_pkg::*;

  logic signed [THR_W-1:0] sx, sy;
  logic [MAX_TRAYS-1:0]    lane_hit;
  logic                    edge_hit;

  assign sx = {{(THR_W-CW-8){1'b0}}, cx, 8'h00};
  assign sy = {{(THR_W-CW-8){1'b0}}, cy, 8'h00};

  for (genvar k = 0; k < MAX_TRAYS; k++) begin : g_hit
    assign lane_hit[k] = lane_en[k] && (sx > div_lo[k]) && (sx < div_hi[k]);
  end

  assign edge_hit = (sx < thr.left) || (sx > thr.right) ||
                    (sy < thr.top) || (sy > thr.bot);
  assign at_margin = edge_hit || (|lane_hit);

endmodule

`default_nettype wire

### design/tmbs_track.sv
// Running best-box state per frame and the result register.
// Depends on tmbs_pkg and assert_macros.svh.
`default_nettype none

module tmbs_track #(
  parameter int MAX_BOXES = 256
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          fire,
  input  wire tmbs_pkg::box_t item,
  input  wire logic          at_margin,
  input  wire logic          res_ready,
  output logic               res_valid,
  output tmbs_pkg::res_t     res_data
);
  import tmbs_pkg::*;

  localparam int CNT_LIMIT = (MAX_BOXES - 1 > 255) ? 255 : MAX_BOXES - 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(CNT_LIMIT);

  logic signed [HT_W-1:0] best_height, best_height_next;
  logic [CNT_W-1:0]       best_position, best_position_next;
  logic [CNT_W-1:0]       box_counter, box_counter_next;
  logic [CW-1:0]          best_x_min, best_x_min_next;
  logic [CW-1:0]          best_y_min, best_y_min_next;
  logic [CW-1:0]          best_x_max, best_x_max_next;
  logic [CW-1:0]          best_y_max, best_y_max_next;
  logic                   have_best, have_best_next;
  logic                   take;
  logic                   frame_end;
  res_t                   res_next;

  assign take      = fire && !at_margin && (item.height_mm > best_height);
  assign frame_end = fire && item.last_box;

  always_comb begin
    best_height_next   = best_height;
    best_position_next = best_position;
    best_x_min_next    = best_x_min;
    best_y_min_next    = best_y_min;
    best_x_max_next    = best_x_max;
    best_y_max_next    = best_y_max;
    have_best_next     = have_best;
    box_counter_next   = box_counter;
    if (take) begin
      best_height_next   = item.height_mm;
      best_position_next = box_counter;
      best_x_min_next    = item.x_min;
      best_y_min_next    = item.y_min;
      best_x_max_next    = item.x_max;
      best_y_max_next    = item.y_max;
      have_best_next     = 1'b1;
    end
    if (fire && (box_counter < CNT_MAX)) begin
      box_counter_next = box_counter + 1'b1;
    end
  end

  // With nothing found every field is still at its cleared zero.
  always_comb begin
    res_next.found      = have_best_next;
    res_next.best_index = best_position_next;
    res_next.center_x   = mid(best_x_min_next, best_x_max_next);
    res_next.center_y   = mid(best_y_min_next, best_y_max_next);
    res_next.best_x_min = best_x_min_next;
    res_next.best_y_min = best_y_min_next;
    res_next.best_x_max = best_x_max_next;
    res_next.best_y_max = best_y_max_next;
  end

  always_ff @(posedge clk) begin
    if (rst || frame_end) begin
      best_height   <= '0;
      best_position <= '0;
      box_counter   <= '0;
      best_x_min    <= '0;
      best_y_min    <= '0;
      best_x_max    <= '0;
      best_y_max    <= '0;
      have_best     <= 1'b0;
    end else begin
      best_height   <= best_height_next;
      best_position <= best_position_next;
      box_counter   <= box_counter_next;
      best_x_min    <= best_x_min_next;
      best_y_min    <= best_y_min_next;
      best_x_max    <= best_x_max_next;
      best_y_max    <= best_y_max_next;
      have_best     <= have_best_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (frame_end) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_end) begin
      res_data <= res_next;
    end
  end

`include "assert_macros.svh"

  `CHK(a_clear_after_last, frame_end |=> box_counter == '0 && !have_best, "frame not cleared")
  `CHK(a_empty_result_zero, res_valid && !res_data.found |-> res_data == '0, "nonzero empty result")
  `CHK_ALWAYS(a_best_positive, have_best |-> best_height > 0, "kept box has non-positive height")
  `CHK(a_count_limit, box_counter <= CNT_MAX, "box counter past its limit")

endmodule

`default_nettype wire

### design/tray_margin_best_box_select.sv
// Tray margin best-box selector. A box transfer is taken into an input register, where the
// centre, the margin tests and the running-maximum update are done, and the result register
// is loaded from that update as the last box of a frame leaves the input register. The rate
// is set by that single compare and update step: one box per cycle, held back only when a
// last box meets a full result register, or while rst is high.
// Margin lines are registered from the configuration registers, not from the write port.
// Depends on tmbs_pkg, tmbs_if, tmbs_cfg, tmbs_near and tmbs_track.
`default_nettype none

module tray_margin_best_box_select #(
  parameter int MAX_TRAYS = 8,
  parameter int MAX_BOXES = 256
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [tmbs_pkg::REG_IDX_W-1:0]    cfg_index,
  input  wire logic [tmbs_pkg::CFG_DATA_W-1:0]   cfg_data,
  tmbs_box_if.sink                               box,
  tmbs_res_if.source                             res
);
  import tmbs_pkg::*;

  thr_t                    thr;
  logic signed [THR_W-1:0] div_lo [MAX_TRAYS];
  logic signed [THR_W-1:0] div_hi [MAX_TRAYS];
  logic [MAX_TRAYS-1:0]    lane_en;

  box_t          item;
  logic          item_valid;
  logic          fire;
  logic          at_margin;
  logic [CW-1:0] cx, cy;

  assign fire      = item_valid && (!item.last_box || !res.valid || res.ready);
  assign box.ready = !rst && (!item_valid || fire);

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (box.valid && box.ready) begin
      item_valid <= 1'b1;
    end else if (fire) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (box.valid && box.ready) begin
      item <= box.data;
    end
  end

  assign cx = mid(item.x_min, item.x_max);
  assign cy = mid(item.y_min, item.y_max);

  tmbs_cfg #(.MAX_TRAYS(MAX_TRAYS)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .thr       (thr),
    .div_lo    (div_lo),
    .div_hi    (div_hi),
    .lane_en   (lane_en)
  );

  tmbs_near #(.MAX_TRAYS(MAX_TRAYS)) u_near (
    .cx        (cx),
    .cy        (cy),
    .thr       (thr),
    .div_lo    (div_lo),
    .div_hi    (div_hi),
    .lane_en   (lane_en),
    .at_margin (at_margin)
  );

  tmbs_track #(.MAX_BOXES(MAX_BOXES)) u_track (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (item),
    .at_margin (at_margin),
    .res_ready (res.ready),
    .res_valid (res.valid),
    .res_data  (res.data)
  );

endmodule

`default_nettype wire

### bench/tmbs_select_check.sv
// Result checker for the tray margin best-box selector: follows register writes and box
// transfers, predicts each frame result and compares every result transfer field by field.
// Depends on tmbs_pkg and the channel interfaces in tmbs_if.
module tmbs_select_check
  import tmbs_pkg::*;
#(
  parameter int MAX_TRAYS = 8,
  parameter int INDEX_CAP = 255
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  tmbs_box_if                   box,
  tmbs_res_if                   res,
  output int                    errors,
  output int                    pending,
  output int                    checked
);

  logic [CW-1:0]          roi_w_px, roi_h_px, tray_w_px;
  logic [3:0]             tray_cnt;
  logic [7:0]             side_q8, edge_q8;
  logic signed [CW-1:0]   row_shift;

  logic signed [HT_W-1:0] top_height;
  logic [CNT_W-1:0]       top_pos, box_pos;
  logic [CW-1:0]          top_x0, top_y0, top_x1, top_y1;
  bit                     have_top;
  res_t                   expected_q[$];

  task automatic report(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    errors++;
  endtask

  task automatic compare_field(input string name, input logic [CW-1:0] got_v,
                               input logic [CW-1:0] want_v);
    if (got_v !== want_v)
      report($sformatf("%s got %0d want %0d", name, got_v, want_v));
  endtask

  // Margin tests kept exact by scaling the centre by 256.
  function automatic bit near_margin(input logic [CW-1:0] cx, input logic [CW-1:0] cy);
    longint tw, rs, re, hh, off, sx, sy, base;
    int     n;
    bit     hit;
    tw  = longint'(tray_w_px);
    rs  = longint'(side_q8);
    re  = longint'(edge_q8);
    hh  = longint'(roi_h_px);
    off = longint'(row_shift) * 256;
    sx  = longint'(cx) * 256;
    sy  = longint'(cy) * 256;
    n   = (int'(tray_cnt) > MAX_TRAYS) ? MAX_TRAYS : int'(tray_cnt);
    hit = (sx < rs * tw) || (sx > longint'(roi_w_px) * 256 - rs * tw) ||
          (sy < re * hh + off) || (sy > (256 - re) * hh + off);
    for (int k = 1; k < n; k++) begin
      base = longint'(k) * 256;
      if (sx > tw * (base - rs) && sx < tw * (base + rs)) hit = 1'b1;
    end
    return hit;
  endfunction

  task automatic clear_selection();
    top_height = '0;
    top_pos    = '0;
    box_pos    = '0;
    top_x0     = '0;
    top_y0     = '0;
    top_x1     = '0;
    top_y1     = '0;
    have_top   = 1'b0;
  endtask

  task automatic absorb_box(input box_t b);
    logic [CW:0] sum_x, sum_y;
    res_t        r;
    sum_x = {1'b0, b.x_min} + {1'b0, b.x_max};
    sum_y = {1'b0, b.y_min} + {1'b0, b.y_max};
    if ($signed(b.height_mm) > top_height && !near_margin(sum_x[CW:1], sum_y[CW:1])) begin
      top_height = b.height_mm;
      top_pos    = box_pos;
      top_x0     = b.x_min;
      top_y0     = b.y_min;
      top_x1     = b.x_max;
      top_y1     = b.y_max;
      have_top   = 1'b1;
    end
    if (int'(box_pos) < INDEX_CAP) box_pos = box_pos + 1'b1;
    if (b.last_box) begin
      r = '0;
      if (have_top) begin
        sum_x        = {1'b0, top_x0} + {1'b0, top_x1};
        sum_y        = {1'b0, top_y0} + {1'b0, top_y1};
        r.found      = 1'b1;
        r.best_index = top_pos;
        r.center_x   = sum_x[CW:1];
        r.center_y   = sum_y[CW:1];
        r.best_x_min = top_x0;
        r.best_y_min = top_y0;
        r.best_x_max = top_x1;
        r.best_y_max = top_y1;
      end
      expected_q = {expected_q, r};
      clear_selection();
    end
  endtask

  task automatic check_result(input res_t got);
    res_t want;
    if (expected_q.size() == 0) begin
      report("result transfer with no frame awaiting it");
      return;
    end
    want = expected_q.pop_front();
    checked++;
    compare_field("found", CW'(got.found), CW'(want.found));
    compare_field("best_index", CW'(got.best_index), CW'(want.best_index));
    compare_field("center_x", got.center_x, want.center_x);
    compare_field("center_y", got.center_y, want.center_y);
    compare_field("best_x_min", got.best_x_min, want.best_x_min);
    compare_field("best_y_min", got.best_y_min, want.best_y_min);
    compare_field("best_x_max", got.best_x_max, want.best_x_max);
    compare_field("best_y_max", got.best_y_max, want.best_y_max);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      roi_w_px  = RST_ROI_WIDTH;
      roi_h_px  = RST_ROI_HEIGHT;
      tray_cnt  = RST_TRAY_COUNT;
      tray_w_px = RST_TRAY_WIDTH;
      side_q8   = RST_SIDE_RATIO;
      edge_q8   = RST_EDGE_RATIO;
      row_shift = RST_ROW_OFFSET;
      clear_selection();
      expected_q.delete();
      errors  = 0;
      checked = 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ROI_WIDTH:  roi_w_px  = cfg_data;
          REG_ROI_HEIGHT: roi_h_px  = cfg_data;
          REG_TRAY_COUNT: tray_cnt  = cfg_data[3:0];
          REG_TRAY_WIDTH: tray_w_px = cfg_data;
          REG_SIDE_RATIO: side_q8   = cfg_data[7:0];
          REG_EDGE_RATIO: edge_q8   = cfg_data[7:0];
          REG_ROW_OFFSET: row_shift = cfg_data;
          default: ;
        endcase
      end
      if (box.valid && box.ready) absorb_box(box.data);
      if (res.valid && res.ready) check_result(res.data);
      pending <= expected_q.size();
    end
  end

endmodule

### bench/tb_top.sv
// Testbench top for tray_margin_best_box_select: clock, reset, register settings, box stimulus
// with random idling and back-pressure, watchdog and verdict.
// Depends on tmbs_pkg, tmbs_if, the block itself and tmbs_select_check.
module tb_top;
  import tmbs_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_BOXES    = 145;
  localparam int SETTLE_CYCLES  = 4;
  localparam int NUM_PHASES     = 8;
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef struct {
    int roi_w;
    int roi_h;
    int trays;
    int tray_w;
    int side_q;
    int edge_q;
    int shift;
  } setting_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [REG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tmbs_box_if box_ch();
  tmbs_res_if res_ch();

  int       mismatches, awaiting, results_checked;
  int       boxes_sent = 0;
  int       quiet = 0;
  int       hold_left;
  int       hold_req = 0;
  int       hold_seen = 0;
  bit       steady = 1'b0;
  setting_t cur;
  setting_t plan[NUM_PHASES];

  tray_margin_best_box_select i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .box       (box_ch),
    .res       (res_ch)
  );

  tmbs_select_check i_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .box       (box_ch),
    .res       (res_ch),
    .errors    (mismatches),
    .pending   (awaiting),
    .checked   (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side: random stalls, or one long hold-off when asked for.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      hold_left    <= 0;
    end else if (hold_left > 0) begin
      res_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      res_ch.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      hold_seen    <= hold_req;
    end else begin
      res_ch.ready <= steady || ($urandom_range(99) >= 30);
    end
  end

  always @(posedge clk) begin
    if (rst || (box_ch.valid && box_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic int clamp_coord(input int v);
    return (v < 0) ? 0 : ((v > 4095) ? 4095 : v);
  endfunction

  function automatic box_t mk_box(input int x0, input int x1, input int y0, input int y1,
                                  input int h, input bit last);
    box_t b;
    b.x_min     = x0[CW-1:0];
    b.x_max     = x1[CW-1:0];
    b.y_min     = y0[CW-1:0];
    b.y_max     = y1[CW-1:0];
    b.height_mm = h[HT_W-1:0];
    b.last_box  = last;
    return b;
  endfunction

  function automatic box_t centred_box(input int h, input bit last);
    int cx, cy;
    cx = cur.roi_w / 2;
    cy = cur.roi_h / 2 + cur.shift;
    return mk_box(clamp_coord(cx - 20), clamp_coord(cx + 20),
                  clamp_coord(cy - 20), clamp_coord(cy + 20), h, last);
  endfunction

  // Mostly boxes inside the region so that selections happen, the rest anywhere.
  function automatic box_t random_box(input bit last);
    box_t b;
    int   x0, y0, pick;
    pick = $urandom_range(99);
    if (pick < 65 && cur.roi_w > 1 && cur.roi_h > 1) begin
      x0 = $urandom_range(cur.roi_w - 1);
      y0 = clamp_coord(int'($urandom_range(cur.roi_h - 1)) + cur.shift);
      b  = mk_box(x0, clamp_coord(x0 + int'($urandom_range(60))),
                  y0, clamp_coord(y0 + int'($urandom_range(60))), 0, last);
    end else begin
      b.x_min = CW'($urandom);
      b.x_max = CW'($urandom);
      b.y_min = CW'($urandom);
      b.y_max = CW'($urandom);
    end
    pick = $urandom_range(99);
    if (pick < 50)      b.height_mm = HT_W'($urandom_range(1, 2000));
    else if (pick < 65) b.height_mm = HT_W'(100 * $urandom_range(1, 3));
    else if (pick < 80) b.height_mm = HT_W'(-int'($urandom_range(100)));
    else                b.height_mm = HT_W'($urandom);
    b.last_box = last;
    return b;
  endfunction

  task automatic send_box(input box_t b);
    if (!steady && $urandom_range(99) < 15) begin
      box_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    box_ch.valid <= 1'b1;
    box_ch.data  <= b;
    @(posedge clk);
    while (!box_ch.ready) @(posedge clk);
    boxes_sent++;
  endtask

  // capped: long frame past the index limit, its tallest box last and centred
  task automatic send_frame(input int len, input bit capped);
    box_t b;
    for (int i = 0; i < len; i++) begin
      b = random_box(i == len - 1);
      if (capped) begin
        if ($signed(b.height_mm) > 20000) b.height_mm = HT_W'(20000);
        if (i == len - 1) b = centred_box(32767, 1'b1);
      end
      send_box(b);
    end
  endtask

  task automatic wait_drained();
    box_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    @(posedge clk);
  endtask

  task automatic load_config(input setting_t s);
    cur = s;
    write_reg(REG_SPARE, $urandom);
    write_reg(REG_ROI_WIDTH, s.roi_w);
    write_reg(REG_ROI_HEIGHT, s.roi_h);
    write_reg(REG_TRAY_COUNT, s.trays);
    write_reg(REG_TRAY_WIDTH, s.tray_w);
    write_reg(REG_SIDE_RATIO, s.side_q);
    write_reg(REG_EDGE_RATIO, s.edge_q);
    write_reg(REG_ROW_OFFSET, s.shift);
    cfg_we <= 1'b0;
    repeat (2) @(posedge clk);
  endtask

  initial begin
    int start;
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    box_ch.valid <= 1'b0;
    box_ch.data  <= '0;

    cur     = '{640, 480, 1, 640, 26, 26, 0};
    plan[0] = '{640, 480, 4, 160, 26, 26, 0};
    plan[1] = '{4095, 4095, 8, 511, 0, 0, 0};
    plan[2] = '{2000, 1500, 8, 250, 13, 40, -2048};
    plan[3] = '{1, 1, 1, 1, 255, 255, 2047};
    plan[4] = '{1024, 768, 3, 341, 64, 20, 100};
    plan[5] = '{0, 0, 0, 0, 30, 30, 0};
    plan[6] = '{800, 600, 15, 100, 20, 20, -50};
    plan[7] = '{640, 480, 2, 320, 26, 26, 0};

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: single box, side and edge margins and non-positive heights, ties,
    // extreme and inverted corners, a frame with nothing eligible
    send_box(mk_box(300, 340, 220, 260, 100, 1'b1));
    send_box(mk_box(300, 340, 220, 260, 0, 1'b0));
    send_box(mk_box(300, 340, 220, 260, -1, 1'b0));
    send_box(mk_box(0, 10, 220, 260, 500, 1'b0));
    send_box(mk_box(630, 639, 220, 260, 500, 1'b0));
    send_box(mk_box(300, 340, 0, 10, 500, 1'b0));
    send_box(mk_box(300, 340, 470, 479, 500, 1'b1));
    send_box(mk_box(280, 300, 200, 220, 300, 1'b0));
    send_box(mk_box(340, 360, 250, 270, 300, 1'b0));
    send_box(mk_box(320, 330, 230, 240, 299, 1'b1));
    send_box(mk_box(4095, 4095, 4095, 4095, 32767, 1'b0));
    send_box(mk_box(0, 0, 0, 0, 32767, 1'b0));
    send_box(mk_box(400, 200, 300, 100, -32768, 1'b0));
    send_box(mk_box(400, 200, 300, 100, 32767, 1'b0));
    send_box(mk_box(300, 340, 220, 260, 32767, 1'b1));
    send_box(mk_box(4095, 0, 4095, 0, 1, 1'b1));

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      load_config(plan[p]);
      start = boxes_sent;
      if (p == 0) begin
        // result side held off while one-box frames keep coming
        hold_req <= hold_req + 1;
        steady   <= 1'b1;
        repeat (40) send_frame(1, 1'b0);
        steady   <= 1'b0;
        wait_drained();
      end
      if (p == 4) send_frame(270, 1'b1);
      if (p == NUM_PHASES - 1) steady <= 1'b1;
      while (boxes_sent - start < PHASE_BOXES) send_frame($urandom_range(1, 10), 1'b0);
    end

    box_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("summary: %0d boxes sent, %0d frame results checked", boxes_sent,
             results_checked);
    $display("summary: %0d register settings incl. reset values, one long result hold-off",
             NUM_PHASES + 1);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/tmbs_pkg.sv
design/tmbs_if.sv
design/tmbs_cfg.sv
design/tmbs_near.sv
design/tmbs_track.sv
design/tray_margin_best_box_select.sv
bench/tmbs_select_check.sv
bench/tb_top.sv
